### rtl/btdc_pkg.sv
// ----------------------------------------------------------------------------
// btdc_pkg
// Shared types and constants for the BCD time-of-day clock unit.
// ----------------------------------------------------------------------------
package btdc_pkg;

    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_START = 2'd1,
        REQ_LOAD  = 2'd2
    } t_req;

    typedef enum logic [1:0] {
        CFG_ALARM_TENTHS  = 2'd0,
        CFG_ALARM_SECONDS = 2'd1,
        CFG_ALARM_MINUTES = 2'd2,
        CFG_ALARM_HOURS   = 2'd3
    } t_cfg_idx;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 8;

    localparam logic [3:0] DIGIT_NINE   = 4'h9;
    localparam logic [6:0] BCD_59       = 7'h59;
    localparam logic [4:0] HOUR_ELEVEN  = 5'h11;
    localparam logic [4:0] HOUR_TWELVE  = 5'h12;
    localparam logic [4:0] HOUR_NINE    = 5'h09;
    localparam logic [4:0] HOUR_TEN     = 5'h10;
    localparam logic [4:0] HOUR_ONE     = 5'h01;
    localparam logic [7:0] HOURS_RESET  = 8'h01;

    typedef struct packed {
        logic [3:0] tenths;
        logic [6:0] seconds;
        logic [6:0] minutes;
        logic [7:0] hours;
        logic       alarm_pulse;
        logic       is_running;
    } t_result;

endpackage

### rtl/bcd_time_of_day_clock_unit.sv
// ----------------------------------------------------------------------------
// bcd_time_of_day_clock_unit
// 12-hour BCD time-of-day clock with tenths, AM/PM flag and alarm pulse.
// ----------------------------------------------------------------------------
// usage:
//   input channel (i_in_valid / o_in_stall) carries one request per
//   transaction: tick, start, or time load. output channel
//   (o_out_valid / i_out_stall) returns one result per request: the time
//   after the request, the alarm pulse and the running flag.
//   alarm registers are written through i_cfg_wr_en / i_cfg_index /
//   i_cfg_data, only while no request is in flight; the user must keep to
//   this, the block does not enforce it. a result is registered in the
//   result register, or in the skid register while the receiver stalls.
//   throughput: one request per cycle while o_in_stall is low; the next
//   state is computed in a single pass from the time registers and the
//   request. the two-entry output stage (result register plus skid
//   register) still takes a request after the receiver stalls, and
//   o_in_stall rises only when both entries hold results. reset: time
//   1:00:00.0 AM, clock stopped, alarms cleared, no result pending.
// ----------------------------------------------------------------------------
module bcd_time_of_day_clock_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,

    input  logic                           i_cfg_wr_en,
    input  logic [btdc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [btdc_pkg::CFG_DATA_W-1:0] i_cfg_data,

    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [1:0]                     i_req_type,
    input  logic [3:0]                     i_load_tenths,
    input  logic [6:0]                     i_load_seconds,
    input  logic [6:0]                     i_load_minutes,
    input  logic [7:0]                     i_load_hours,

    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [3:0]                     o_now_tenths,
    output logic [6:0]                     o_now_seconds,
    output logic [6:0]                     o_now_minutes,
    output logic [7:0]                     o_now_hours,
    output logic                           o_alarm_pulse,
    output logic                           o_is_running
);

    function automatic logic [6:0] bcd_step7(input logic [6:0] v);
        logic [6:0] r;
        if (v[3:0] == btdc_pkg::DIGIT_NINE) begin
            r = {v[6:4] + 3'd1, 4'h0};
        end else begin
            r = {v[6:4], v[3:0] + 4'd1};
        end
        return r;
    endfunction

    function automatic logic [7:0] hour_step(input logic [7:0] h);
        logic       pm;
        logic [4:0] hr;
        pm = h[7];
        hr = h[4:0];
        if (hr == btdc_pkg::HOUR_ELEVEN) begin
            pm = ~pm;
        end
        if (hr == btdc_pkg::HOUR_TWELVE) begin
            hr = btdc_pkg::HOUR_ONE;
        end else if (hr == btdc_pkg::HOUR_NINE) begin
            hr = btdc_pkg::HOUR_TEN;
        end else begin
            hr = {hr[4], hr[3:0] + 4'd1};
        end
        return {pm, 2'b00, hr};
    endfunction

    // alarm registers
    logic [3:0] r_alarm_tenths;
    logic [6:0] r_alarm_seconds;
    logic [6:0] r_alarm_minutes;
    logic [7:0] r_alarm_hours;

    // time state
    logic [3:0] r_tenths,  n_tenths;
    logic [6:0] r_seconds, n_seconds;
    logic [6:0] r_minutes, n_minutes;
    logic [7:0] r_hours,   n_hours;
    logic       r_running, n_running;
    logic       r_match,   n_match;

    // output stage
    btdc_pkg::t_result r_out, r_skid, n_result;
    logic              r_out_valid, r_skid_valid;

    logic              in_accept;
    logic              out_free;
    logic              eq;
    logic              pulse;
    btdc_pkg::t_req    req;

    assign in_accept = i_in_valid & ~r_skid_valid;
    assign out_free  = ~r_out_valid | ~i_out_stall;
    assign req       = btdc_pkg::t_req'(i_req_type);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alarm_tenths  <= '0;
            r_alarm_seconds <= '0;
            r_alarm_minutes <= '0;
            r_alarm_hours   <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (btdc_pkg::t_cfg_idx'(i_cfg_index))
                btdc_pkg::CFG_ALARM_TENTHS:  r_alarm_tenths  <= i_cfg_data[3:0];
                btdc_pkg::CFG_ALARM_SECONDS: r_alarm_seconds <= i_cfg_data[6:0];
                btdc_pkg::CFG_ALARM_MINUTES: r_alarm_minutes <= i_cfg_data[6:0];
                btdc_pkg::CFG_ALARM_HOURS:   r_alarm_hours   <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_tenths  = r_tenths;
        n_seconds = r_seconds;
        n_minutes = r_minutes;
        n_hours   = r_hours;
        n_running = r_running;
        n_match   = r_match;
        pulse     = 1'b0;
        eq        = 1'b0;
        unique case (req)
            btdc_pkg::REQ_TICK: begin
                if (r_running) begin
                    if (r_tenths != btdc_pkg::DIGIT_NINE) begin
                        n_tenths = r_tenths + 4'd1;
                    end else begin
                        n_tenths = '0;
                        if (r_seconds != btdc_pkg::BCD_59) begin
                            n_seconds = bcd_step7(r_seconds);
                        end else begin
                            n_seconds = '0;
                            if (r_minutes != btdc_pkg::BCD_59) begin
                                n_minutes = bcd_step7(r_minutes);
                            end else begin
                                n_minutes = '0;
                                n_hours   = hour_step(r_hours);
                            end
                        end
                    end
                    eq = (n_tenths == r_alarm_tenths) && (n_seconds == r_alarm_seconds) &&
                         (n_minutes == r_alarm_minutes) && (n_hours == r_alarm_hours);
                    pulse   = eq & ~r_match;
                    n_match = eq;
                end
            end
            btdc_pkg::REQ_START: begin
                n_running = 1'b1;
            end
            btdc_pkg::REQ_LOAD: begin
                n_tenths  = i_load_tenths;
                n_seconds = i_load_seconds;
                n_minutes = i_load_minutes;
                n_hours   = i_load_hours;
            end
            default: ;
        endcase
        n_result.tenths      = n_tenths;
        n_result.seconds     = n_seconds;
        n_result.minutes     = n_minutes;
        n_result.hours       = n_hours;
        n_result.alarm_pulse = pulse;
        n_result.is_running  = n_running;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tenths  <= '0;
            r_seconds <= '0;
            r_minutes <= '0;
            r_hours   <= btdc_pkg::HOURS_RESET;
            r_running <= 1'b0;
            r_match   <= 1'b0;
        end else if (in_accept) begin
            r_tenths  <= n_tenths;
            r_seconds <= n_seconds;
            r_minutes <= n_minutes;
            r_hours   <= n_hours;
            r_running <= n_running;
            r_match   <= n_match;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= in_accept;
            end
        end else if (in_accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (in_accept) begin
                r_out <= n_result;
            end
        end else if (in_accept) begin
            r_skid <= n_result;
        end
    end

    assign o_in_stall    = r_skid_valid;
    assign o_out_valid   = r_out_valid;
    assign o_now_tenths  = r_out.tenths;
    assign o_now_seconds = r_out.seconds;
    assign o_now_minutes = r_out.minutes;
    assign o_now_hours   = r_out.hours;
    assign o_alarm_pulse = r_out.alarm_pulse;
    assign o_is_running  = r_out.is_running;

`ifndef SYNTHESIS
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register full while result register empty");

    a_pulse_only_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.alarm_pulse) |-> r_out.is_running)
        else $error("alarm pulse while clock stopped");

    a_start_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_req_type == btdc_pkg::REQ_START) |=> r_running)
        else $error("start transaction did not set running flag");

    a_pulse_sets_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && pulse) |=> r_match)
        else $error("alarm pulse without match flag");
`endif

endmodule
